FILE: src/tcc_pkg.sv
// Shared types and constants for the trinucleotide context counter.
// Holds the input and result beat structs, opcode codes and the decode struct.
// No dependencies.
package tcc_pkg;

    localparam int NUM_BINS = 96;
    localparam int LANES = 3;
    localparam int NUM_ROWS = 32;
    localparam int ROW_W = 5;

    localparam logic [1:0] OP_SEQ = 2'd0;
    localparam logic [1:0] OP_HDR = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [2:0] BASE_A = 3'd0;
    localparam logic [2:0] BASE_G = 3'd1;
    localparam logic [2:0] BASE_C = 3'd2;
    localparam logic [2:0] BASE_T = 3'd3;
    localparam logic [2:0] NO_BASE = 3'd4;

    localparam logic [4:0] MAX_CHROM_RESET = 5'd24;
    localparam logic [0:0] REG_MAX_CHROM = 1'd0;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] base_char;
        logic [6:0] read_bin;
    } tcc_in_t;

    typedef struct packed {
        logic        context_valid;
        logic [6:0]  context_bin;
        logic [31:0] count_value;
        logic        stopped_flag;
    } tcc_out_t;

    typedef struct packed {
        logic       window_valid;
        logic [6:0] context_bin;
        logic       is_read;
        logic       read_ok;
        logic [1:0] lane;
        logic       stopped;
    } tcc_dec_t;

endpackage

FILE: src/tcc_front.sv
// Decode stage: base encoding, window folding, header counting and stop state.
// Depends on tcc_pkg.
module tcc_front
    import tcc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  tcc_in_t          item,
    input  logic             accept,
    input  logic [4:0]       max_chromosomes,
    output tcc_dec_t         dec,
    output logic [ROW_W-1:0] row
);

    logic [2:0] older_reg, older_next;
    logic [2:0] newer_reg, newer_next;
    logic [4:0] chrom_reg, chrom_next;
    logic       stopped_reg, stopped_next;

    logic [2:0]       third;
    logic [1:0]       f_base;
    logic [1:0]       t_base;
    logic             m_bit;
    logic [ROW_W-1:0] ctx_row;
    logic [6:0]       ctx_bin;
    logic             win_ok;
    logic [12:0]      prod;
    logic [5:0]       quot;
    logic [7:0]       rem_full;

    function automatic logic [2:0] encode_base(input logic [7:0] ch);
        logic [2:0] code;
        case (ch)
            8'h41:   code = BASE_A;
            8'h47:   code = BASE_G;
            8'h43:   code = BASE_C;
            8'h54:   code = BASE_T;
            default: code = NO_BASE;
        endcase
        return code;
    endfunction

    always_comb
    begin
        third = encode_base(item.base_char);
        win_ok = (item.opcode == OP_SEQ) && !stopped_reg
                 && !older_reg[2] && !newer_reg[2] && !third[2];
        if (!newer_reg[1])
        begin
            f_base = ~third[1:0];
            t_base = ~older_reg[1:0];
            m_bit  = newer_reg[0];
        end
        else
        begin
            f_base = older_reg[1:0];
            t_base = third[1:0];
            m_bit  = ~newer_reg[0];
        end
        ctx_row = {f_base, m_bit, t_base};
        ctx_bin = {1'b0, ctx_row, 1'b0} + {2'b00, ctx_row};

        prod = 13'(item.read_bin) * 13'd43;
        quot = prod[12:7];
        rem_full = {1'b0, item.read_bin} - ({2'b00, quot} + {1'b0, quot, 1'b0});

        older_next   = older_reg;
        newer_next   = newer_reg;
        chrom_next   = chrom_reg;
        stopped_next = stopped_reg;
        case (item.opcode)
            OP_SEQ:
            begin
                if (!stopped_reg)
                begin
                    older_next = newer_reg;
                    newer_next = third;
                end
            end
            OP_HDR:
            begin
                if (!stopped_reg)
                begin
                    if (chrom_reg >= max_chromosomes)
                    begin
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        chrom_next = chrom_reg + 5'd1;
                        older_next = NO_BASE;
                        newer_next = NO_BASE;
                    end
                end
            end
            default:
            begin
            end
        endcase

        dec.window_valid = win_ok;
        dec.context_bin  = win_ok ? ctx_bin : 7'd0;
        dec.is_read      = (item.opcode == OP_READ);
        dec.read_ok      = (item.read_bin < 7'(NUM_BINS));
        dec.lane         = rem_full[1:0];
        dec.stopped      = stopped_next;
        row = (item.opcode == OP_READ) ? quot[ROW_W-1:0] : ctx_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg   <= NO_BASE;
            newer_reg   <= NO_BASE;
            chrom_reg   <= 5'd0;
            stopped_reg <= 1'b0;
        end
        else if (accept)
        begin
            older_reg   <= older_next;
            newer_reg   <= newer_next;
            chrom_reg   <= chrom_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

FILE: src/tcc_count_mem.sv
// Histogram storage: 32 rows of three counters, one write and one read port.
// Rows read as zero until first written; a write to the row being read is forwarded.
// Depends on tcc_pkg.
module tcc_count_mem
    import tcc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         we,
    input  logic [ROW_W-1:0]             waddr,
    input  logic [LANES*COUNT_WIDTH-1:0] wdata,
    input  logic                         re,
    input  logic [ROW_W-1:0]             raddr,
    output logic [LANES*COUNT_WIDTH-1:0] rdata
);

    logic [LANES*COUNT_WIDTH-1:0] mem [NUM_ROWS];
    logic [NUM_ROWS-1:0]          row_valid_reg;
    logic [LANES*COUNT_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else if (row_valid_reg[raddr])
            begin
                rdata_reg <= mem[raddr];
            end
            else
            begin
                rdata_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (we)
        begin
            row_valid_reg[waddr] <= 1'b1;
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/tcc_bump.sv
// Update stage: saturating increment of the three counters of a row and bin readout.
// Depends on tcc_pkg.
module tcc_bump
    import tcc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic [LANES*COUNT_WIDTH-1:0] row_in,
    input  tcc_dec_t                     dec,
    output logic [LANES*COUNT_WIDTH-1:0] row_out,
    output tcc_out_t                     result
);

    logic [COUNT_WIDTH-1:0] lane_val;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (row_in[i*COUNT_WIDTH +: COUNT_WIDTH] == {COUNT_WIDTH{1'b1}})
            begin
                row_out[i*COUNT_WIDTH +: COUNT_WIDTH] = row_in[i*COUNT_WIDTH +: COUNT_WIDTH];
            end
            else
            begin
                row_out[i*COUNT_WIDTH +: COUNT_WIDTH] =
                    row_in[i*COUNT_WIDTH +: COUNT_WIDTH] + COUNT_WIDTH'(1);
            end
        end

        case (dec.lane)
            2'd0:    lane_val = row_in[0 +: COUNT_WIDTH];
            2'd1:    lane_val = row_in[COUNT_WIDTH +: COUNT_WIDTH];
            2'd2:    lane_val = row_in[2*COUNT_WIDTH +: COUNT_WIDTH];
            default: lane_val = '0;
        endcase

        result.context_valid = dec.window_valid;
        result.context_bin   = dec.context_bin;
        result.count_value   = (dec.is_read && dec.read_ok) ? 32'(lane_val) : 32'd0;
        result.stopped_flag  = dec.stopped;
    end

endmodule

FILE: src/trinucleotide_context_counter.sv
// Top level of the trinucleotide context counter.
// Instantiates tcc_front, tcc_count_mem and tcc_bump; depends on tcc_pkg.
//
// The block accepts one beat per clock cycle while in_stall is low and returns exactly
// one result beat for each. The result beat is registered in the output stage after
// the decode stage and is offered until taken. Each beat is decoded and its histogram
// row (three adjacent bins) is read in the accept cycle; the next stage applies the
// saturating increment, writes the row back and registers the result. A write to a
// row that the following beat reads is forwarded, so back-to-back updates of one row
// need no wait. The block holds at most two beats, and a stalled output holds off the
// input once both are occupied. The histogram reads as all zero after reset with no
// clearing pass. The chromosome limit is written through the APB port while the block
// idles; the user is bound to this, and the block itself does not enforce it.
module trinucleotide_context_counter
    import tcc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  tcc_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output tcc_out_t    out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [4:0]                   max_chrom_reg;
    logic                         s1_valid_reg;
    tcc_dec_t                     s1_dec_reg;
    logic [ROW_W-1:0]             s1_row_reg;
    logic                         out_valid_reg;
    tcc_out_t                     out_data_reg;

    logic                         in_accept;
    logic                         s1_adv;
    tcc_dec_t                     dec;
    logic [ROW_W-1:0]             row;
    logic [LANES*COUNT_WIDTH-1:0] row_rd;
    logic [LANES*COUNT_WIDTH-1:0] row_wr;
    tcc_out_t                     result;
    logic                         cfg_write;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[1:0] == {1'b0, REG_MAX_CHROM}) ? {27'd0, max_chrom_reg}
                                                             : {27'd0, max_chrom_reg};
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    tcc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (in_data),
        .accept          (in_accept),
        .max_chromosomes (max_chrom_reg),
        .dec             (dec),
        .row             (row)
    );

    tcc_count_mem #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (s1_adv && s1_dec_reg.window_valid),
        .waddr (s1_row_reg),
        .wdata (row_wr),
        .re    (in_accept),
        .raddr (row),
        .rdata (row_rd)
    );

    tcc_bump #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_bump (
        .row_in  (row_rd),
        .dec     (s1_dec_reg),
        .row_out (row_wr),
        .result  (result)
    );

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_dec_reg <= dec;
            s1_row_reg <= row;
        end
        if (s1_adv)
        begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_chrom_reg <= MAX_CHROM_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                max_chrom_reg <= pwdata[4:0];
            end
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: verif/tb_trinucleotide_context_counter.sv
// Self-checking testbench for trinucleotide_context_counter: drives character, header and
// read beats through random idle and stall phases and checks every result beat against
// an in-bench histogram model. Depends on tcc_pkg and the RTL only.
module tb_trinucleotide_context_counter
    import tcc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [7:0] CHAR_A = "A";
    localparam logic [7:0] CHAR_G = "G";
    localparam logic [7:0] CHAR_C = "C";
    localparam logic [7:0] CHAR_T = "T";
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_LEN = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    tcc_in_t     in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    tcc_out_t    out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    tcc_in_t     char_stream[$];
    tcc_out_t    due_results[$];
    int          idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_armed = 1'b0;
    logic        hold_taken;
    int          hold_left;
    int          quiet_cycles = 0;
    int          mismatches = 0;

    logic [2:0]  win_older = NO_BASE;
    logic [2:0]  win_newer = NO_BASE;
    logic [4:0]  chrom_seen = '0;
    logic [4:0]  chrom_limit = MAX_CHROM_RESET;
    logic        halted = 1'b0;
    logic [31:0] bin_counts [NUM_BINS];

    trinucleotide_context_counter u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [2:0] base_code(logic [7:0] ch);
        case (ch)
            CHAR_A: return BASE_A;
            CHAR_G: return BASE_G;
            CHAR_C: return BASE_C;
            CHAR_T: return BASE_T;
            default: return NO_BASE;
        endcase
    endfunction

    function automatic tcc_out_t step_histogram(tcc_in_t beat);
        tcc_out_t   res;
        logic [2:0] third;
        logic [2:0] f;
        logic [2:0] m;
        logic [2:0] t;
        int         bin;
        res = '0;
        if (beat.opcode == OP_SEQ && !halted)
        begin
            third = base_code(beat.base_char);
            if (win_older < NO_BASE && win_newer < NO_BASE && third < NO_BASE)
            begin
                f = win_older;
                m = win_newer;
                t = third;
                if (m == BASE_A || m == BASE_G)
                begin
                    f = BASE_T - third;
                    t = BASE_T - win_older;
                end
                else
                begin
                    m = BASE_T - m;
                end
                bin = int'(f) * 24 + int'(m) * 12 + int'(t) * 3;
                for (int k = 0; k < LANES; k++)
                begin
                    if (bin_counts[bin + k] != '1)
                        bin_counts[bin + k] = bin_counts[bin + k] + 32'd1;
                end
                res.context_valid = 1'b1;
                res.context_bin = 7'(bin);
            end
            win_older = win_newer;
            win_newer = third;
        end
        else if (beat.opcode == OP_HDR && !halted)
        begin
            if (chrom_seen >= chrom_limit)
            begin
                halted = 1'b1;
            end
            else
            begin
                chrom_seen = chrom_seen + 5'd1;
                win_older = NO_BASE;
                win_newer = NO_BASE;
            end
        end
        else if (beat.opcode == OP_READ)
        begin
            if (beat.read_bin < NUM_BINS)
                res.count_value = bin_counts[beat.read_bin];
        end
        res.stopped_flag = halted;
        return res;
    endfunction

    // Mostly well-formed bases, with noise characters, headers, reads and the unused opcode.
    function automatic tcc_in_t random_beat();
        tcc_in_t beat;
        int      r;
        r = $urandom_range(99);
        beat.opcode = OP_SEQ;
        beat.base_char = 8'($urandom);
        beat.read_bin = 7'($urandom);
        if (r < 70)
        begin
            case ($urandom_range(3))
                0: beat.base_char = CHAR_A;
                1: beat.base_char = CHAR_G;
                2: beat.base_char = CHAR_C;
                default: beat.base_char = CHAR_T;
            endcase
        end
        else if (r < 78)
        begin
            beat.opcode = OP_SEQ;
        end
        else if (r < 80)
        begin
            beat.opcode = OP_HDR;
        end
        else if (r < 96)
        begin
            beat.opcode = OP_READ;
            if ($urandom_range(9) == 0)
                beat.read_bin = 7'($urandom_range(127, NUM_BINS));
            else
                beat.read_bin = 7'($urandom_range(NUM_BINS - 1));
        end
        else
        begin
            beat.opcode = OP_UNUSED;
        end
        return beat;
    endfunction

    task automatic push_beat(logic [1:0] op, logic [7:0] ch, logic [6:0] bin);
        tcc_in_t beat;
        beat.opcode = op;
        beat.base_char = ch;
        beat.read_bin = bin;
        char_stream = {char_stream, beat};
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (char_stream.size() != 0 || in_valid || due_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_phase(int count, int idle, int stall);
        @(negedge clk);
        idle_pct = idle;
        stall_pct = stall;
        repeat (count) char_stream = {char_stream, random_beat()};
        drain();
    endtask

    task automatic write_chrom_limit(logic [4:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 2'(4 * int'(REG_MAX_CHROM));
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        chrom_limit = value;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (char_stream.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                in_valid <= 1'b1;
                in_data <= char_stream.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_taken <= 1'b0;
        end
        else if (hold_armed && !hold_taken)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_LEN;
            hold_taken <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        tcc_out_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("unexpected result beat %h", out_data);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (out_data.context_valid !== want.context_valid)
                    begin
                        $error("context_valid: expected %0d, got %0d",
                               want.context_valid, out_data.context_valid);
                        mismatches++;
                    end
                    if (out_data.context_bin !== want.context_bin)
                    begin
                        $error("context_bin: expected %0d, got %0d",
                               want.context_bin, out_data.context_bin);
                        mismatches++;
                    end
                    if (out_data.count_value !== want.count_value)
                    begin
                        $error("count_value: expected %0d, got %0d",
                               want.count_value, out_data.count_value);
                        mismatches++;
                    end
                    if (out_data.stopped_flag !== want.stopped_flag)
                    begin
                        $error("stopped_flag: expected %0d, got %0d",
                               want.stopped_flag, out_data.stopped_flag);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                due_results = {due_results, step_histogram(in_data)};
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < NUM_BINS; i++)
            bin_counts[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        push_beat(OP_SEQ, CHAR_C, '0);
        push_beat(OP_SEQ, CHAR_A, '0);
        push_beat(OP_SEQ, CHAR_T, '0);
        push_beat(OP_HDR, '0, '0);
        push_beat(OP_SEQ, CHAR_A, '0);
        push_beat(OP_SEQ, CHAR_C, '0);
        push_beat(OP_SEQ, CHAR_G, '0);
        push_beat(OP_SEQ, CHAR_T, '0);
        push_beat(OP_SEQ, CHAR_G, '0);
        push_beat(OP_SEQ, CHAR_A, '0);
        push_beat(OP_SEQ, "N", '0);
        push_beat(OP_SEQ, CHAR_C, '0);
        push_beat(OP_SEQ, CHAR_A, '0);
        push_beat(OP_SEQ, CHAR_A, '0);
        push_beat(OP_SEQ, 8'h00, '0);
        push_beat(OP_SEQ, 8'hFF, '0);
        push_beat(OP_SEQ, "a", '0);
        push_beat(OP_READ, '0, 7'd0);
        push_beat(OP_READ, '0, 7'd95);
        push_beat(OP_READ, '0, 7'd96);
        push_beat(OP_READ, 8'hFF, 7'd127);
        push_beat(OP_UNUSED, 8'hFF, 7'd127);
        push_beat(OP_HDR, '0, '0);
        drain();

        write_chrom_limit(5'd31);
        @(negedge clk);
        hold_armed = 1'b1;
        run_phase(200, 0, 0);
        write_chrom_limit(5'($urandom_range(31, 24)));
        run_phase(200, 68, 0);
        write_chrom_limit(5'd31);
        run_phase(200, 0, 68);
        run_phase(150, 7, 7);

        write_chrom_limit(5'd1);
        @(negedge clk);
        push_beat(OP_SEQ, CHAR_G, '0);
        push_beat(OP_HDR, '0, '0);
        run_phase(60, 0, 0);

        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
